/* sv/cbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// item layouts, configuration and bank state types, code constants and
// the small size decode functions
// ----------------------------------------------------------------------------
package cbm_pkg;

	// command codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// controller kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_MBC1 = 2'd1;
	localparam logic [1:0] KIND_MBC3 = 2'd2;
	localparam logic [1:0] KIND_MBC5 = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_KIND     = 2'd0;
	localparam logic [1:0] CFG_ROM_SIZE = 2'd1;
	localparam logic [1:0] CFG_RAM_SIZE = 2'd2;
	localparam logic [1:0] CFG_RUMBLE   = 2'd3;

	// ram size codes
	localparam logic [2:0] RAM_NONE = 3'd0;
	localparam logic [2:0] RAM_2K   = 3'd1;
	localparam logic [2:0] RAM_8K   = 3'd2;
	localparam logic [2:0] RAM_32K  = 3'd3;
	localparam logic [2:0] RAM_128K = 3'd4;
	localparam logic [2:0] RAM_64K  = 3'd5;

	// result regions
	localparam logic [1:0] REGION_ROM   = 2'd0;
	localparam logic [1:0] REGION_RAM   = 2'd1;
	localparam logic [1:0] REGION_OTHER = 2'd2;
	localparam logic [1:0] REGION_OFF   = 2'd3;

	// register windows below 0x8000, picked by address bits 14:13
	localparam logic [1:0] WIN_RAM_EN   = 2'd0;
	localparam logic [1:0] WIN_ROM_BANK = 2'd1;
	localparam logic [1:0] WIN_RAM_BANK = 2'd2;
	localparam logic [1:0] WIN_MODE     = 2'd3;

	// 0xa000-0xbfff sits at address bits 15:13 == 101
	localparam logic [2:0] CART_RAM_TOP = 3'b101;
	localparam logic [3:0] RAM_ENABLE_KEY = 4'ha;

	localparam int ROM_OFS_W  = 14;
	localparam int RAM_OFS_W  = 13;
	localparam int CFG_DATA_W = 4;
	localparam int PHYS_W     = 23;

	typedef struct packed {
		logic        command;
		logic [15:0] address;
		logic [7:0]  write_data;
	} cbm_in_t;

	typedef struct packed {
		logic [1:0]        region;
		logic [PHYS_W-1:0] physical_address;
		logic              store_write;
		logic              read_all_ones;
	} cbm_out_t;

	typedef struct packed {
		logic [1:0] controller_kind;
		logic [3:0] rom_size_code;
		logic [2:0] ram_size_code;
		logic       rumble_cart;
	} cbm_cfg_t;

	typedef struct packed {
		logic [7:0] rom_bank;
		logic [3:0] ram_page;
		logic [6:0] mbc1_bits;
		logic       ram_enabled;
		logic       banking_mode;
	} cbm_bank_t;

	// rom bank mask: 2 << code banks, codes 7 and up give the full byte
	function automatic logic [7:0] rom_mask_f(input logic [3:0] code);
		logic [7:0] m;
		if (code >= 4'd7) begin
			m = 8'hff;
		end else begin
			m = 8'hff >> (3'd7 - code[2:0]);
		end
		return m;
	endfunction

	// ram bank mask, zero when the ram holds one bank or less
	function automatic logic [3:0] ram_mask_f(input logic [2:0] code);
		logic [3:0] m;
		unique case (code)
			RAM_32K:  m = 4'h3;
			RAM_128K: m = 4'hf;
			RAM_64K:  m = 4'h7;
			default:  m = 4'h0;
		endcase
		return m;
	endfunction

	// offset inside the 8 KiB window lies within the ram
	function automatic logic ram_in_range_f(input logic [2:0] code,
			input logic [RAM_OFS_W-1:0] ofs);
		logic ok;
		case (code) inside
			RAM_2K:                             ok = (ofs[12:11] == 2'b00);
			RAM_8K, RAM_32K, RAM_128K, RAM_64K: ok = 1'b1;
			default:                            ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

/* sv/cbm_bank_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_bank_regs: bank register file
// decodes register writes of the item in stage 1 and gives the bank state
// as it stands after that item; the state is committed when the item moves on
// ----------------------------------------------------------------------------
module cbm_bank_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cbm_pkg::cbm_cfg_t cfg,
	input  wire cbm_pkg::cbm_in_t  item_s1,
	input  wire logic              advance,
	output cbm_pkg::cbm_bank_t     bank_after
);
	import cbm_pkg::*;

	cbm_bank_t  bank_q;
	cbm_bank_t  nxt;
	logic [7:0] rmask;
	logic [3:0] bmask;
	logic [7:0] rom_val;
	logic [4:0] mbc1_low;
	logic [3:0] ram_val;
	logic       ram_sel;
	logic       mbc1_apply;
	logic       is_mbc1;

	assign rmask   = rom_mask_f(cfg.rom_size_code);
	assign bmask   = ram_mask_f(cfg.ram_size_code);
	assign is_mbc1 = (cfg.controller_kind == KIND_MBC1);

	always_comb begin
		nxt        = bank_q;
		rom_val    = item_s1.write_data;
		mbc1_low   = item_s1.write_data[4:0];
		ram_val    = 4'd0;
		ram_sel    = 1'b0;
		mbc1_apply = 1'b0;

		if (cfg.controller_kind == KIND_MBC3) begin
			rom_val = {1'b0, item_s1.write_data[6:0]};
		end
		if (rom_val == 8'd0) begin
			rom_val = 8'd1;
		end
		if (mbc1_low == 5'd0) begin
			mbc1_low = 5'd1;
		end

		if (item_s1.command == CMD_WRITE && !item_s1.address[15]
				&& cfg.controller_kind != KIND_NONE) begin
			unique case (item_s1.address[14:13])
				WIN_RAM_EN: begin
					nxt.ram_enabled = (item_s1.write_data[3:0] == RAM_ENABLE_KEY);
				end
				WIN_ROM_BANK: begin
					if (is_mbc1) begin
						nxt.mbc1_bits = {bank_q.mbc1_bits[6:5], mbc1_low};
						mbc1_apply    = 1'b1;
					end else begin
						nxt.rom_bank = rom_val & rmask;
					end
				end
				WIN_RAM_BANK: begin
					if (is_mbc1) begin
						nxt.mbc1_bits = {item_s1.write_data[1:0], bank_q.mbc1_bits[4:0]};
						mbc1_apply    = 1'b1;
					end else begin
						ram_sel = 1'b1;
						ram_val = cfg.rumble_cart ? {1'b0, item_s1.write_data[2:0]}
							: item_s1.write_data[3:0];
					end
				end
				WIN_MODE: begin
					if (is_mbc1) begin
						nxt.banking_mode = item_s1.write_data[0];
						mbc1_apply       = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// mbc1: mode 1 splits the 7 bits into rom low bits and ram bank
		if (mbc1_apply) begin
			ram_sel = 1'b1;
			if (nxt.banking_mode) begin
				nxt.rom_bank = {3'b000, nxt.mbc1_bits[4:0]} & rmask;
				ram_val      = {2'b00, nxt.mbc1_bits[6:5]};
			end else begin
				nxt.rom_bank = {1'b0, nxt.mbc1_bits} & rmask;
				ram_val      = 4'd0;
			end
		end

		// small ram keeps its bank
		if (ram_sel && bmask != 4'd0) begin
			nxt.ram_page = ram_val & bmask;
		end
	end

	assign bank_after = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q.rom_bank     <= 8'd1;
			bank_q.ram_page     <= 4'd0;
			bank_q.mbc1_bits    <= 7'd1;
			bank_q.ram_enabled  <= 1'b0;
			bank_q.banking_mode <= 1'b0;
		end else if (advance) begin
			bank_q <= nxt;
		end
	end

endmodule
`default_nettype wire

/* sv/cbm_addr_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_addr_map: address decode and mapping
// turns a bus access and the bank state into region, physical address and
// the write and read flags
// ----------------------------------------------------------------------------
module cbm_addr_map (
	input  wire cbm_pkg::cbm_cfg_t  cfg,
	input  wire cbm_pkg::cbm_in_t   item_s1,
	input  wire cbm_pkg::cbm_bank_t bank,
	output cbm_pkg::cbm_out_t       result
);
	import cbm_pkg::*;

	logic [15:0] addr;
	logic        ram_ok;

	assign addr   = item_s1.address;
	assign ram_ok = bank.ram_enabled && ram_in_range_f(cfg.ram_size_code, addr[12:0]);

	always_comb begin
		result = '0;
		if (!addr[15]) begin
			result.region = REGION_ROM;
			if (!addr[14]) begin
				result.physical_address = {7'd0, addr};
			end else begin
				result.physical_address = {1'b0, bank.rom_bank, addr[ROM_OFS_W-1:0]};
			end
		end else if (addr[15:13] == CART_RAM_TOP) begin
			if (ram_ok) begin
				result.region           = REGION_RAM;
				result.physical_address = {6'd0, bank.ram_page, addr[RAM_OFS_W-1:0]};
			end else begin
				result.region = REGION_OFF;
			end
		end else begin
			result.region           = REGION_OTHER;
			result.physical_address = {7'd0, addr};
		end

		if (item_s1.command == CMD_WRITE) begin
			result.store_write = (result.region == REGION_RAM)
				|| (result.region == REGION_OTHER);
		end else begin
			result.read_all_ones = (result.region == REGION_OFF);
		end
	end

endmodule
`default_nettype wire

/* sv/cartridge_bank_mapper_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit: cartridge memory bank controller
// pipeline: input register, then result register; throughput: one item
//   per cycle while out_stall does not hold the result register
// the bank registers are updated as an item leaves stage 1, so the next
//   item already sees them
// reset: configuration clears to zero, rom bank 1, ram bank 0, ram disabled
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// access items
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire cbm_pkg::cbm_in_t                 in_item,
	// mapped results
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output cbm_pkg::cbm_out_t                     out_item,
	// configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cbm_pkg::*;

	cbm_cfg_t  cfg_q;
	cbm_in_t   item_s1;
	logic      valid_s1;
	cbm_out_t  result_s2;
	logic      valid_s2;
	cbm_bank_t bank_after;
	cbm_out_t  result;
	logic      out_free;
	logic      advance;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KIND:     cfg_q.controller_kind <= cfg_data[1:0];
				CFG_ROM_SIZE: cfg_q.rom_size_code   <= cfg_data;
				CFG_RAM_SIZE: cfg_q.ram_size_code   <= cfg_data[2:0];
				CFG_RUMBLE:   cfg_q.rumble_cart     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// result register is free when empty or being taken this cycle
	assign out_free = !valid_s2 || !out_stall;
	// stage 1 item moves on to the result register
	assign advance  = valid_s1 && out_free;
	// stage 1 can take a new item when it is empty or moving on
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// bank registers, read-modify for the item in stage 1
	cbm_bank_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_s1    (item_s1),
		.advance    (advance),
		.bank_after (bank_after)
	);

	// mapping uses the bank state after this item's own write
	cbm_addr_map u_map (
		.cfg     (cfg_q),
		.item_s1 (item_s1),
		.bank    (bank_after),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the cartridge bank mapper
// every accepted bus access goes through a local model of the bank registers,
// and the mapping it predicts is queued; each result the block hands out is
// checked field by field against the oldest queued mapping. directed
// accesses come first, then random bank-switch sequences under a range of
// controller kinds and rom/ram sizes, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb;
	import cbm_pkg::*;

	localparam int ROM_BANK_BYTES = 16384;
	localparam int RAM_BANK_BYTES = 8192;
	// two register stages inside the block, plus some slack
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int PHASE_ITEMS    = 100;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	cbm_in_t               in_item;
	logic                  out_valid;
	logic                  out_stall;
	cbm_out_t              out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// local copy of the configuration and the bank registers
	cbm_cfg_t  cfg_st;
	cbm_bank_t bank_st;

	// mappings waiting for the block to produce them, oldest first
	cbm_out_t  mapped_q[$];

	int   mismatch_count = 0;
	int   sent_count     = 0;
	// idling controls of the sender and the stall process
	bit   send_idle      = 1'b0;
	bit   recv_idle      = 1'b0;
	int   hold_left      = 0;
	int   stall_run      = 0;
	logic stall_val      = 1'b0;

	cartridge_bank_mapper_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// bank register model
	// ------------------------------------------------------------------------

	// gap length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// rom holds 2 << code banks; codes 7 and up keep the whole byte
	function automatic logic [7:0] rom_bank_mask(input logic [3:0] code);
		logic [8:0] banks;
		if (code >= 4'd7) return 8'hff;
		banks = 9'd2 << code;
		return 8'(banks - 9'd1);
	endfunction

	// unknown size codes count as no ram
	function automatic int ram_byte_count(input logic [2:0] code);
		case (code)
			RAM_2K:   return 2048;
			RAM_8K:   return 8192;
			RAM_32K:  return 32768;
			RAM_128K: return 131072;
			RAM_64K:  return 65536;
			default:  return 0;
		endcase
	endfunction

	function automatic void select_rom_bank(input logic [7:0] bank);
		bank_st.rom_bank = bank & rom_bank_mask(cfg_st.rom_size_code);
	endfunction

	// a ram of one bank or less never switches
	function automatic void select_ram_bank(input logic [7:0] bank);
		int bytes;
		bytes = ram_byte_count(cfg_st.ram_size_code);
		if (bytes > RAM_BANK_BYTES)
			bank_st.ram_page = 4'(bank & 8'(bytes / RAM_BANK_BYTES - 1));
	endfunction

	// mbc1: mode 1 splits the seven bits into rom low bits and ram bank
	function automatic void mbc1_reselect();
		if (bank_st.banking_mode) begin
			select_rom_bank({3'b000, bank_st.mbc1_bits[4:0]});
			select_ram_bank({6'b0, bank_st.mbc1_bits[6:5]});
		end else begin
			select_rom_bank({1'b0, bank_st.mbc1_bits});
			select_ram_bank(8'd0);
		end
	endfunction

	function automatic void bank_register_write(input logic [15:0] addr, input logic [7:0] val);
		logic [7:0] v;
		logic       is_mbc1;
		v = val;
		is_mbc1 = (cfg_st.controller_kind == KIND_MBC1);
		if (cfg_st.controller_kind == KIND_NONE) return;
		case (addr[14:13])
			WIN_RAM_EN: bank_st.ram_enabled = (val[3:0] == RAM_ENABLE_KEY);
			WIN_ROM_BANK: begin
				if (is_mbc1) v = val & 8'h1f;
				else if (cfg_st.controller_kind == KIND_MBC3) v = val & 8'h7f;
				// a bank number of zero written to this window is taken as one
				if (v == 8'd0) v = 8'd1;
				if (is_mbc1) begin
					bank_st.mbc1_bits = {bank_st.mbc1_bits[6:5], v[4:0]};
					mbc1_reselect();
				end else begin
					select_rom_bank(v);
				end
			end
			WIN_RAM_BANK: begin
				if (is_mbc1) begin
					bank_st.mbc1_bits = {val[1:0], bank_st.mbc1_bits[4:0]};
					mbc1_reselect();
				end else begin
					if (cfg_st.rumble_cart) v = val & 8'h07;
					select_ram_bank(v);
				end
			end
			WIN_MODE: begin
				if (is_mbc1) begin
					bank_st.banking_mode = val[0];
					mbc1_reselect();
				end
			end
		endcase
	endfunction

	// one bus access: update the bank registers, then map with the new values
	function automatic cbm_out_t map_access(input cbm_in_t acc);
		cbm_out_t    res;
		logic [12:0] ofs;
		int          phys;
		res = '0;
		phys = 0;
		ofs = acc.address[12:0];
		if (acc.command == CMD_WRITE && !acc.address[15])
			bank_register_write(acc.address, acc.write_data);
		if (!acc.address[15]) begin
			res.region = REGION_ROM;
			if (!acc.address[14]) phys = int'(acc.address);
			else phys = int'(bank_st.rom_bank) * ROM_BANK_BYTES + int'(acc.address[13:0]);
		end else if (acc.address[15:13] == CART_RAM_TOP) begin
			// disabled ram or an offset past a small ram reads as ones
			if (bank_st.ram_enabled && int'(ofs) < ram_byte_count(cfg_st.ram_size_code)) begin
				res.region = REGION_RAM;
				phys = int'(bank_st.ram_page) * RAM_BANK_BYTES + int'(ofs);
			end else begin
				res.region = REGION_OFF;
			end
		end else begin
			res.region = REGION_OTHER;
			phys = int'(acc.address);
		end
		res.physical_address = PHYS_W'(phys);
		if (acc.command == CMD_WRITE)
			res.store_write = (res.region == REGION_RAM || res.region == REGION_OTHER);
		else
			res.read_all_ones = (res.region == REGION_OFF);
		return res;
	endfunction

	function automatic void reset_model();
		cfg_st = '0;
		bank_st = '0;
		bank_st.rom_bank = 8'd1;
		bank_st.mbc1_bits = 7'd1;
	endfunction

	function automatic cbm_in_t make_access(input logic cmd, input logic [15:0] addr,
			input logic [7:0] data);
		cbm_in_t acc;
		acc.command = cmd;
		acc.address = addr;
		acc.write_data = data;
		return acc;
	endfunction

	// random address inside an 8 KiB window
	function automatic logic [15:0] addr_in(input logic [15:0] base);
		return base | 16'($urandom_range(0, 16'h1fff));
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// outputs are sampled at the rising edge, before the block updates them
	always @(posedge clk) begin : check_results
		cbm_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (mapped_q.size() == 0) begin
				report_mismatch("unexpected item", 32'(out_item.physical_address), 32'd0);
			end else begin
				want = mapped_q.pop_front();
				if (out_item.region !== want.region)
					report_mismatch("region", 32'(out_item.region), 32'(want.region));
				if (out_item.physical_address !== want.physical_address)
					report_mismatch("physical_address", 32'(out_item.physical_address),
						32'(want.physical_address));
				if (out_item.store_write !== want.store_write)
					report_mismatch("store_write", 32'(out_item.store_write),
						32'(want.store_write));
				if (out_item.read_all_ones !== want.read_all_ones)
					report_mismatch("read_all_ones", 32'(out_item.read_all_ones),
						32'(want.read_all_ones));
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver stall: a forced hold-off has priority, else, with recv_idle set, random runs
	// ------------------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!recv_idle) begin
				out_stall <= 1'b0;
			end else begin
				if (stall_run == 0) begin
					stall_val = ($urandom_range(0, 2) == 0);
					stall_run = stall_val ? pick_gap() : $urandom_range(1, 6);
					if (stall_run == 0) stall_run = 1;
				end
				out_stall <= stall_val;
				stall_run--;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender and configuration
	// ------------------------------------------------------------------------

	// offer one access and hold it until taken; valid stays up between
	// back-to-back items
	task automatic send_access(input cbm_in_t acc);
		int gap;
		gap = send_idle ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= acc;
		do @(posedge clk); while (in_stall);
		mapped_q.push_back(map_access(acc));
		sent_count++;
	endtask

	task automatic idle_sender();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// stop sending and let every pending mapping come out
	task automatic wait_drain();
		idle_sender();
		while (mapped_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_KIND:     cfg_st.controller_kind = data[1:0];
			CFG_ROM_SIZE: cfg_st.rom_size_code = data;
			CFG_RAM_SIZE: cfg_st.ram_size_code = data[2:0];
			CFG_RUMBLE:   cfg_st.rumble_cart = data[0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// new cartridge setup, only with the block idle
	task automatic set_mapper(input logic [1:0] kind, input logic [3:0] rom_code,
			input logic [2:0] ram_code, input logic rumble);
		wait_drain();
		write_register(CFG_KIND, {2'b00, kind});
		write_register(CFG_ROM_SIZE, rom_code);
		write_register(CFG_RAM_SIZE, {1'b0, ram_code});
		write_register(CFG_RUMBLE, {3'b000, rumble});
	endtask

	// typical game code: enable ram, pick banks, then touch the windows
	task automatic bank_sequence();
		int         n;
		logic [7:0] key;
		key = {4'($urandom), RAM_ENABLE_KEY};
		if ($urandom_range(0, 5) == 0) key = 8'($urandom);
		send_access(make_access(CMD_WRITE, addr_in(16'h0000), key));
		if ($urandom_range(0, 3) != 0)
			send_access(make_access(CMD_WRITE, addr_in(16'h2000),
				($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom)));
		if ($urandom_range(0, 2) != 0)
			send_access(make_access(CMD_WRITE, addr_in(16'h4000), 8'($urandom)));
		if ($urandom_range(0, 2) == 0)
			send_access(make_access(CMD_WRITE, addr_in(16'h6000), 8'($urandom)));
		n = $urandom_range(2, 8);
		repeat (n) begin
			case ($urandom_range(0, 4))
				0, 1: send_access(make_access(1'($urandom), addr_in(16'ha000), 8'($urandom)));
				2: send_access(make_access(CMD_READ,
					16'h4000 | 16'($urandom_range(0, 16'h3fff)), 8'($urandom)));
				3: send_access(make_access(CMD_READ,
					16'($urandom_range(0, 16'h3fff)), 8'($urandom)));
				default: send_access(make_access(1'($urandom),
					$urandom_range(0, 1) ? addr_in(16'h8000)
						: 16'($urandom_range(16'hc000, 16'hffff)),
					8'($urandom)));
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset setup has no controller: register writes do nothing, ram is off
	task automatic test_no_controller();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_access(make_access(CMD_WRITE, 16'h0000, 8'h0a));
		send_access(make_access(CMD_READ, 16'ha000, 8'h00));
		send_access(make_access(CMD_WRITE, 16'hbfff, 8'hff));
		send_access(make_access(CMD_READ, 16'h4000, 8'h00));
		send_access(make_access(CMD_READ, 16'hffff, 8'h00));
		send_access(make_access(CMD_WRITE, 16'h8000, 8'h5a));
		send_access(make_access(CMD_READ, 16'h3fff, 8'h00));
	endtask

	// mbc1: zero bank, full low bits, upper bits, mode 1, ram enable key
	task automatic test_mbc1_banking();
		set_mapper(KIND_MBC1, 4'd6, RAM_32K, 1'b0);
		send_access(make_access(CMD_WRITE, 16'h2000, 8'h00));
		send_access(make_access(CMD_READ, 16'h7fff, 8'h00));
		send_access(make_access(CMD_WRITE, 16'h3fff, 8'hff));
		send_access(make_access(CMD_WRITE, 16'h4000, 8'h03));
		send_access(make_access(CMD_READ, 16'h4000, 8'h00));
		send_access(make_access(CMD_WRITE, 16'h6000, 8'h01));
		send_access(make_access(CMD_WRITE, 16'h1fff, 8'h1a));
		send_access(make_access(CMD_WRITE, 16'ha000, 8'h55));
		send_access(make_access(CMD_READ, 16'hbfff, 8'h00));
		send_access(make_access(CMD_WRITE, 16'h0000, 8'h0b));
		send_access(make_access(CMD_READ, 16'ha123, 8'h00));
	endtask

	// mbc5 with 2 KiB ram: offsets past the ram read as ones, bank 0xff
	task automatic test_small_ram_mbc5();
		set_mapper(KIND_MBC5, 4'd15, RAM_2K, 1'b1);
		send_access(make_access(CMD_WRITE, 16'h0000, 8'h0a));
		send_access(make_access(CMD_READ, 16'ha7ff, 8'h00));
		send_access(make_access(CMD_READ, 16'ha800, 8'h00));
		send_access(make_access(CMD_WRITE, 16'h4000, 8'hff));
		send_access(make_access(CMD_WRITE, 16'h2000, 8'h00));
		send_access(make_access(CMD_WRITE, 16'h2000, 8'hff));
		send_access(make_access(CMD_READ, 16'h7fff, 8'h00));
		send_access(make_access(CMD_WRITE, 16'hc000, 8'hff));
	endtask

	// receiver holds off while the sender keeps offering back to back,
	// then the sender waits for everything to come out
	task automatic test_full_stall();
		wait_drain();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_left = 64;
		repeat (40) send_access(make_access(1'($urandom), 16'($urandom), 8'($urandom)));
		wait_drain();
	endtask

	// random bank sequences and noise across many cartridge setups
	task automatic test_random_mappings();
		int phase;
		int stop_at;
		int end_at;
		phase = 0;
		end_at = sent_count + RANDOM_ITEMS;
		while (sent_count < end_at) begin
			case (phase)
				0: set_mapper(KIND_MBC1, 4'd4, RAM_32K, 1'b0);
				1: set_mapper(KIND_MBC1, 4'd6, RAM_2K, 1'b0);
				2: set_mapper(KIND_MBC3, 4'd0, RAM_8K, 1'b1);
				3: set_mapper(KIND_MBC5, 4'd8, RAM_128K, 1'b1);
				4: set_mapper(KIND_MBC5, 4'd15, RAM_64K, 1'b0);
				5: set_mapper(KIND_NONE, 4'd2, RAM_32K, 1'b0);
				6: set_mapper(KIND_MBC3, 4'd7, 3'd7, 1'b0);
				7: set_mapper(KIND_MBC1, 4'd0, RAM_128K, 1'b1);
				default: set_mapper(($urandom_range(0, 9) == 0) ? KIND_NONE
						: 2'($urandom_range(1, 3)),
					4'($urandom), 3'($urandom), 1'($urandom));
			endcase
			// some phases run flat out on one side or both
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			stop_at = sent_count + PHASE_ITEMS;
			while (sent_count < stop_at) begin
				if ($urandom_range(0, 3) != 0)
					bank_sequence();
				else
					send_access(make_access(1'($urandom), 16'($urandom), 8'($urandom)));
			end
			phase++;
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : run_tests
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_no_controller();
		test_mbc1_banking();
		test_small_ram_mbc5();
		test_full_stall();
		test_random_mappings();

		// let the tail drain, bounded in case the block hangs
		idle_sender();
		for (waited = 0; mapped_q.size() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mapped_q.size() != 0)
			report_mismatch("items never delivered", 32'(mapped_q.size()), 32'd0);
		if (mismatch_count == 0)
			$display("[cartridge_bank_mapper_unit] OK");
		else
			$display("[cartridge_bank_mapper_unit] ERROR");
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#4_000_000;
		$display("[cartridge_bank_mapper_unit] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
sv/cbm_pkg.sv
sv/cbm_bank_regs.sv
sv/cbm_addr_map.sv
sv/cartridge_bank_mapper_unit.sv
tb/tb.sv
